// ----- hw/rtl/swmf_pkg.sv -----
package swmf_pkg;

  // Frame index width used inside the block
  localparam int unsigned TIME_BITS_DEF = 32;

  // Fixed field widths of the channels and registers
  localparam int unsigned FIELD_W   = 32;
  localparam int unsigned WIN_LEN_W = 32;
  localparam int unsigned THR_W     = 24;
  localparam int unsigned PROD_W    = WIN_LEN_W + THR_W;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 32;

  // Fraction bits of the Q8.16 threshold
  localparam int unsigned THR_FRAC = 16;

  // Register reset values
  localparam logic [WIN_LEN_W-1:0] WIN_LEN_RST = WIN_LEN_W'(100);
  localparam logic [THR_W-1:0]     THR_RST     = THR_W'(32768);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 1'b1;

  // Request codes
  typedef enum logic {
    REQ_SEGMENT = 1'b0,
    REQ_FLUSH   = 1'b1
  } req_type_e;

endpackage

// ----- hw/rtl/swmf_if.sv -----
// Segment input channel
interface swmf_in_if;
  logic                             valid;
  logic                             ready;
  logic                             req_type;
  logic [swmf_pkg::FIELD_W-1:0]     seg_begin;
  logic [swmf_pkg::FIELD_W-1:0]     seg_length;

  modport source (output valid, req_type, seg_begin, seg_length, input ready);
  modport sink   (input valid, req_type, seg_begin, seg_length, output ready);
endinterface

// Merged segment output channel
interface swmf_out_if;
  logic                             valid;
  logic                             ready;
  logic [swmf_pkg::FIELD_W-1:0]     out_begin;
  logic [swmf_pkg::FIELD_W-1:0]     out_length;
  logic [swmf_pkg::FIELD_W-1:0]     covered_frames;

  modport source (output valid, out_begin, out_length, covered_frames, input ready);
  modport sink   (input valid, out_begin, out_length, covered_frames, output ready);
endinterface

// ----- hw/rtl/segment_window_merge_filter_top.sv -----
// Segment window merge filter. Takes one word per cycle on in_i (a segment or an
// end-of-list flush) unless stalled by out_o or a pending configuration write:
// each word passes an input register, then compare/add logic that updates the
// window state and loads the output register, from which a merged segment is
// presented on out_o. Back-pressure on out_o stalls both stages. A window
// closes when a segment ends beyond start + win_length, or on a flush; it is
// emitted only if covered frames are non-zero and covered * 2^16 >=
// threshold_q16 * win_length. That product is registered from the configuration
// registers, and in_i is held not ready in the cycle after a configuration write
// while prod_q is updated. Frame values wider than TIME_BITS saturate.
module segment_window_merge_filter_top #(
  parameter int unsigned TIME_BITS = swmf_pkg::TIME_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [swmf_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [swmf_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  swmf_in_if.sink                             in_i,
  swmf_out_if.source                          out_o
);

  localparam int unsigned TW     = TIME_BITS;
  localparam int unsigned SUM_W  = ((TW > swmf_pkg::WIN_LEN_W) ? TW : swmf_pkg::WIN_LEN_W) + 1;
  localparam int unsigned FRQ_W  = TW + swmf_pkg::THR_FRAC;
  localparam int unsigned CMP_W  = (FRQ_W > swmf_pkg::PROD_W) ? FRQ_W : swmf_pkg::PROD_W;
  localparam logic [63:0] TIME_MAX = (64'(1) << TW) - 64'(1);

  // configuration registers and threshold product
  logic [swmf_pkg::WIN_LEN_W-1:0] win_len_q;
  logic [swmf_pkg::THR_W-1:0]     thr_q;
  logic [swmf_pkg::PROD_W-1:0]    prod_q;
  logic                           cfg_pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q  <= swmf_pkg::WIN_LEN_RST;
      thr_q      <= swmf_pkg::THR_RST;
      prod_q     <= swmf_pkg::PROD_W'(swmf_pkg::THR_RST) *
                    swmf_pkg::PROD_W'(swmf_pkg::WIN_LEN_RST);
      cfg_pend_q <= 1'b0;
    end else begin
      cfg_pend_q <= cfg_we_i;
      prod_q     <= swmf_pkg::PROD_W'(thr_q) * swmf_pkg::PROD_W'(win_len_q);
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          swmf_pkg::CFG_WIN_LENGTH: win_len_q <= cfg_data_i[swmf_pkg::WIN_LEN_W-1:0];
          swmf_pkg::CFG_THRESHOLD:  thr_q     <= cfg_data_i[swmf_pkg::THR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // input saturation to the frame width
  logic [TW-1:0] begin_sat, len_sat;
  assign begin_sat = (64'(in_i.seg_begin) > TIME_MAX) ? '1 : TW'(in_i.seg_begin);
  assign len_sat   = (64'(in_i.seg_length) > TIME_MAX) ? '1 : TW'(in_i.seg_length);

  // input register
  logic          in_vld_q;
  logic          in_flush_q;
  logic [TW-1:0] in_begin_q;
  logic [TW-1:0] in_len_q;
  logic          fire;
  logic          in_acc;

  assign in_i.ready = !cfg_pend_q && (!in_vld_q || fire);
  assign in_acc     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_acc) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_flush_q <= (in_i.req_type == swmf_pkg::REQ_FLUSH);
      in_begin_q <= begin_sat;
      in_len_q   <= len_sat;
    end
  end

  // window state
  logic          win_open_q;
  logic [TW-1:0] win_start_q;
  logic [TW-1:0] win_frames_q;
  logic [TW:0]   win_last_q;

  // absorb test, coverage test and merged span
  logic          out_vld_q;
  logic [TW:0]   excl;
  logic [SUM_W-1:0] limit;
  logic          absorb;
  logic [TW:0]   frames_sum;
  logic [TW-1:0] frames_sat;
  logic          qualify;
  logic          emit;
  logic [TW:0]   span_diff;
  logic [TW-1:0] span;

  assign fire       = in_vld_q && (!out_vld_q || out_o.ready);
  assign excl       = (TW+1)'(in_begin_q) + (TW+1)'(in_len_q);
  assign limit      = SUM_W'(win_start_q) + SUM_W'(win_len_q);
  assign absorb     = !in_flush_q && win_open_q && (SUM_W'(excl) <= limit);
  assign frames_sum = (TW+1)'(win_frames_q) + (TW+1)'(in_len_q);
  assign frames_sat = frames_sum[TW] ? '1 : frames_sum[TW-1:0];
  assign qualify    = win_open_q && (win_frames_q != '0) &&
                      (CMP_W'({win_frames_q, {swmf_pkg::THR_FRAC{1'b0}}}) >= CMP_W'(prod_q));
  assign emit       = qualify && !absorb;
  assign span_diff  = win_last_q - (TW+1)'(win_start_q);
  assign span       = (win_last_q <= (TW+1)'(win_start_q)) ? TW'(1) :
                      (span_diff[TW] ? '1 : span_diff[TW-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_open_q   <= 1'b0;
      win_start_q  <= '0;
      win_frames_q <= '0;
      win_last_q   <= '0;
    end else if (fire) begin
      if (in_flush_q) begin
        win_open_q <= 1'b0;
      end else if (absorb) begin
        win_frames_q <= frames_sat;
        win_last_q   <= excl;
      end else begin
        win_open_q   <= 1'b1;
        win_start_q  <= in_begin_q;
        win_frames_q <= in_len_q;
        win_last_q   <= excl;
      end
    end
  end

  // output register
  logic [swmf_pkg::FIELD_W-1:0] out_begin_q, out_length_q, out_cov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= emit;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      out_begin_q  <= swmf_pkg::FIELD_W'(win_start_q);
      out_length_q <= swmf_pkg::FIELD_W'(span);
      out_cov_q    <= swmf_pkg::FIELD_W'(win_frames_q);
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.out_begin      = out_begin_q;
  assign out_o.out_length     = out_length_q;
  assign out_o.covered_frames = out_cov_q;

endmodule
